/* hw/rtl/vgbb_pkg.sv */
// Shared types and constants of the voxel grid bounding box block.
`default_nettype none

package vgbb_pkg;

   // Column geometry
   localparam int WORD_BITS        = 32;
   localparam int WORDS_PER_COLUMN = 4;
   localparam int BIT_W            = $clog2(WORD_BITS);
   localparam int Z_W              = $clog2(WORD_BITS * WORDS_PER_COLUMN);

   // Divider geometry
   localparam int SPAN_W     = 13;
   localparam int DIV_W      = 21;
   localparam int DVR_W      = 9;
   localparam int STEP_CNT_W = 5;
   localparam logic [STEP_CNT_W-1:0] DIVN_STEPS = 5'd21;
   localparam logic [STEP_CNT_W-1:0] DIVS_STEPS = 5'd14;
   localparam logic [STEP_CNT_W-1:0] DIVM_STEPS = 5'd7;

   // Register port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_X_SCALE     = 3'd0;
   localparam logic [2:0] REG_Y_SCALE     = 3'd1;
   localparam logic [2:0] REG_DEPTH_SCALE = 3'd2;
   localparam logic [2:0] REG_GRID_DEPTH  = 3'd3;
   localparam logic [2:0] REG_TABLE_SIZE  = 3'd4;
   localparam logic [2:0] REG_STEP_Z      = 3'd5;

   // Request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_VOXEL = 2'd1;
   localparam logic [1:0] REQ_EMIT  = 2'd2;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [11:0]          col_x;
      logic [11:0]          col_y;
      logic [1:0]           word_index;
      logic [WORD_BITS-1:0] voxel_word;
      logic [11:0]          table_index;
      logic [15:0]          table_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
      logic               box_empty;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0]       x_scale;
      logic [31:0]       y_scale;
      logic [31:0]       depth_scale;
      logic [7:0]        grid_depth;
      logic [SPAN_W-1:0] table_size;
      logic [7:0]        step_z;
   } cfg_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } box_upd_type;

endpackage

`default_nettype wire

/* hw/rtl/vgbb_csr.sv */
// Configuration registers behind the APB-style port.
`default_nettype none

module vgbb_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [vgbb_pkg::CSR_AW-1:0]  paddr,
   input  logic [vgbb_pkg::CSR_DW-1:0]  pwdata,
   output logic [vgbb_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output vgbb_pkg::cfg_type            cfg
);
   import vgbb_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_scale     <= 32'h0001_0000;
         cfg_ff.y_scale     <= 32'h0001_0000;
         cfg_ff.depth_scale <= 32'h0001_0000;
         cfg_ff.grid_depth  <= 8'd128;
         cfg_ff.table_size  <= 13'd4096;
         cfg_ff.step_z      <= 8'd1;
      end else if (wr_en) begin
         case (reg_idx)
            REG_X_SCALE:     cfg_ff.x_scale     <= pwdata;
            REG_Y_SCALE:     cfg_ff.y_scale     <= pwdata;
            REG_DEPTH_SCALE: cfg_ff.depth_scale <= pwdata;
            REG_GRID_DEPTH:  cfg_ff.grid_depth  <= pwdata[7:0];
            REG_TABLE_SIZE:  cfg_ff.table_size  <= pwdata[SPAN_W-1:0];
            REG_STEP_Z:      cfg_ff.step_z      <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_X_SCALE:     prdata = cfg_ff.x_scale;
         REG_Y_SCALE:     prdata = cfg_ff.y_scale;
         REG_DEPTH_SCALE: prdata = cfg_ff.depth_scale;
         REG_GRID_DEPTH:  prdata = CSR_DW'(cfg_ff.grid_depth);
         REG_TABLE_SIZE:  prdata = CSR_DW'(cfg_ff.table_size);
         REG_STEP_Z:      prdata = CSR_DW'(cfg_ff.step_z);
         default:         prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/vgbb_div.sv */
// Restoring divider, one quotient bit per cycle, numerator left aligned.
`default_nettype none

module vgbb_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [vgbb_pkg::DIV_W-1:0]       num,
   input  logic [vgbb_pkg::DVR_W-1:0]       dvr,
   input  logic [vgbb_pkg::STEP_CNT_W-1:0]  steps,
   output logic                             done,
   output logic [vgbb_pkg::DIV_W-1:0]       quo,
   output logic [vgbb_pkg::DVR_W-1:0]       rem
);
   import vgbb_pkg::*;

   logic [DIV_W-1:0]      num_ff;
   logic [DIV_W-1:0]      quo_ff;
   logic [DVR_W-1:0]      rem_ff;
   logic [DVR_W-1:0]      dvr_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DVR_W:0]        part;
   logic [DVR_W+1:0]      trial;

   // partial remainder stays below twice the divisor
   assign part  = {rem_ff, num_ff[DIV_W-1]};
   assign trial = {1'b0, part} - {2'b00, dvr_ff};

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_CNT_W'(1);
            if (cnt_ff == STEP_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         num_ff <= num;
         dvr_ff <= dvr;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         if (!trial[DVR_W+1]) begin
            rem_ff <= trial[DVR_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= part[DVR_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/vgbb_box.sv */
// Running min/max box and the result output register.
`default_nettype none

module vgbb_box (
   input  logic                   clock,
   input  logic                   reset,
   input  vgbb_pkg::box_upd_type  upd,
   input  logic                   emit,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vgbb_pkg::rsp_word_type rsp_data
);
   import vgbb_pkg::*;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;

   logic signed [31:0] lo_x_ff, lo_y_ff, lo_z_ff;
   logic signed [31:0] hi_x_ff, hi_y_ff, hi_z_ff;
   logic               any_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (any_ff) begin
         rsp_in.min_x     = lo_x_ff;
         rsp_in.min_y     = lo_y_ff;
         rsp_in.min_z     = lo_z_ff;
         rsp_in.max_x     = hi_x_ff;
         rsp_in.max_y     = hi_y_ff;
         rsp_in.max_z     = hi_z_ff;
         rsp_in.box_empty = 1'b0;
      end else begin
         rsp_in           = '0;
         rsp_in.box_empty = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_x_ff      <= POS_MAX;
         lo_y_ff      <= POS_MAX;
         lo_z_ff      <= POS_MAX;
         hi_x_ff      <= NEG_MAX;
         hi_y_ff      <= NEG_MAX;
         hi_z_ff      <= NEG_MAX;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            lo_x_ff <= POS_MAX;
            lo_y_ff <= POS_MAX;
            lo_z_ff <= POS_MAX;
            hi_x_ff <= NEG_MAX;
            hi_y_ff <= NEG_MAX;
            hi_z_ff <= NEG_MAX;
            any_ff  <= 1'b0;
         end else if (upd.hit) begin
            lo_x_ff <= (upd.x < lo_x_ff) ? upd.x : lo_x_ff;
            lo_y_ff <= (upd.y < lo_y_ff) ? upd.y : lo_y_ff;
            lo_z_ff <= (upd.z < lo_z_ff) ? upd.z : lo_z_ff;
            hi_x_ff <= (upd.x > hi_x_ff) ? upd.x : hi_x_ff;
            hi_y_ff <= (upd.y > hi_y_ff) ? upd.y : hi_y_ff;
            hi_z_ff <= (upd.z > hi_z_ff) ? upd.z : hi_z_ff;
            any_ff  <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/voxel_grid_bounding_box_core.sv */
// Voxel grid bounding box: top level with sequencer, shared multiplier and depth table.
//
// Usage: software writes the scale, depth and step registers over the csr_ port
// while the block is idle, then loads the depth table with req_type load words
// (one entry each). Voxel words (req_type voxel) widen a running box of cell
// centers; an emit word returns the box on rsp_ and clears it.
// Channels: req_ (valid/ready) in, rsp_ (valid/ready) out, one word each.
// Sequence: after acceptance a voxel word holds req_ready low while the shared
// multiplier forms x, y and the table-index numerator, the one-bit-per-cycle
// divider makes three passes, the scan walks the 32 occupancy bits (one table
// read and multiply per bit) and the drain states S_DRAIN1 and S_DRAIN2 empty
// the z pipeline; no new word is taken until the voxel word has drained.
// An emit word is taken when the output register is free, and the box shows on
// rsp_ the next cycle.
// Stall: while a result waits on rsp_ready, loads and voxel words still go in;
// only a further emit waits.
// Reset: registers return to their reset values and the box is empty; depth
// table contents are undefined until loaded.
`default_nettype none

module voxel_grid_bounding_box_core #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  vgbb_pkg::req_word_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output vgbb_pkg::rsp_word_type       rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vgbb_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [vgbb_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [vgbb_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import vgbb_pkg::*;

   localparam int          TAB_AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [31:0] TAB_LAST = 32'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MULX, S_MULY, S_MULN,
      S_DIVN_GO, S_DIVN_WAIT, S_DIVS_GO, S_DIVS_WAIT, S_DIVM_GO, S_DIVM_WAIT,
      S_SCAN, S_DRAIN1, S_DRAIN2
   } state_type;

   cfg_type               cfg;
   state_type             state_ff, state_in;

   // column context
   logic [11:0]           cx_ff, cy_ff;
   logic [Z_W-1:0]        z_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [BIT_W-1:0]      bit_ff;

   // incremental table index: q + r/D, advanced by dq + dr/D per depth cell
   logic [DIV_W-1:0]      q_ff;
   logic [DVR_W-1:0]      r_ff;
   logic [SPAN_W:0]       dq_ff;
   logic [DVR_W-1:0]      dr_ff;
   logic [7:0]            m_ff;

   logic signed [31:0]    px_ff, py_ff;
   logic [47:0]           prod_ff;
   logic [15:0]           rd_ff;
   logic                  v1_ff, v2_ff;

   logic [15:0]           table_mem [TABLE_DEPTH];

   logic [7:0]            step_eff;
   logic [SPAN_W-1:0]     span;
   logic [DVR_W-1:0]      dvr_gd;
   logic                  req_acc, voxel_go, mem_we, emit, rsp_free;
   logic [TAB_AW-1:0]     wr_addr, rd_addr;
   logic [31:0]           mul_a;
   logic [15:0]           mul_b;
   logic [47:0]           mul_p;
   logic                  div_start, div_done;
   logic [DIV_W-1:0]      div_num, div_quo;
   logic [DVR_W-1:0]      div_dvr, div_rem;
   logic [STEP_CNT_W-1:0] div_steps;
   logic [48:0]           xy_rnd, z_rnd;
   logic [47:0]           xy_val;
   logic signed [31:0]    xy_ctr, pz;
   logic [32:0]           z_mag, z_sat, z_neg;
   logic [31:0]           q_clip;
   logic                  hit0;
   logic [DVR_W:0]        r_sum;
   logic                  r_wrap;
   logic [DVR_W-1:0]      r_next;
   logic [DIV_W-1:0]      q_next;
   logic [8:0]            m_inc;
   logic [7:0]            m_next;
   box_upd_type           upd;

   vgbb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // derived config
   assign step_eff = (cfg.step_z == 8'd0) ? 8'd1 : cfg.step_z;
   assign span     = (cfg.table_size < SPAN_W'(2)) ? '0 : cfg.table_size - SPAN_W'(1);
   assign dvr_gd   = {cfg.grid_depth, 1'b0};

   // request side
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && ((req_data.req_type != REQ_EMIT) || rsp_free);
   assign req_acc   = req_valid && req_ready;
   assign voxel_go  = req_acc && (req_data.req_type == REQ_VOXEL)
                      && (32'(req_data.word_index) < 32'(WORDS_PER_COLUMN));
   assign mem_we    = req_acc && (req_data.req_type == REQ_LOAD)
                      && (32'(req_data.table_index) < 32'(TABLE_DEPTH));
   assign emit      = req_acc && (req_data.req_type == REQ_EMIT);
   assign wr_addr   = TAB_AW'({{TAB_AW{1'b0}}, req_data.table_index});

   // shared multiplier, product registered in prod_ff
   always_comb begin
      case (state_ff)
         S_MULX: begin
            mul_a = cfg.x_scale;
            mul_b = 16'({cx_ff, 1'b1});
         end
         S_MULY: begin
            mul_a = cfg.y_scale;
            mul_b = 16'({cy_ff, 1'b1});
         end
         S_MULN: begin
            mul_a = 32'(span);
            mul_b = 16'({z_ff, 1'b1});
         end
         default: begin
            mul_a = cfg.depth_scale;
            mul_b = rd_ff;
         end
      endcase
   end
   assign mul_p = 48'(mul_a) * 48'(mul_b);

   // x/y center: halve rounding half up, clamp to the largest positive value
   assign xy_rnd = {1'b0, prod_ff} + 49'd1;
   assign xy_val = xy_rnd[48:1];
   assign xy_ctr = (|xy_val[47:31]) ? 32'sh7FFF_FFFF : $signed(xy_val[31:0]);

   // z center: drop 16 fraction bits rounding half up, clamp at 2^31, negate
   assign z_rnd = {1'b0, prod_ff} + 49'h8000;
   assign z_mag = z_rnd[48:16];
   assign z_sat = (z_mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : z_mag;
   assign z_neg = 33'd0 - z_sat;
   assign pz    = $signed(z_neg[31:0]);

   // divider launches
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_dvr   = dvr_gd;
      div_steps = DIVN_STEPS;
      case (state_ff)
         S_DIVN_GO: begin
            // ((2z+1)*span + grid_depth) / (2*grid_depth)
            div_start = 1'b1;
            div_num   = prod_ff[DIV_W-1:0] + DIV_W'(cfg.grid_depth);
            div_steps = DIVN_STEPS;
         end
         S_DIVS_GO: begin
            // per-cell increment 2*span / (2*grid_depth)
            div_start = 1'b1;
            div_num   = DIV_W'({span, 1'b0, 7'b0000000});
            div_steps = DIVS_STEPS;
         end
         S_DIVM_GO: begin
            // phase of the first cell against the depth stride
            div_start = 1'b1;
            div_num   = DIV_W'({z_ff, 14'b0});
            div_dvr   = {1'b0, step_eff};
            div_steps = DIVM_STEPS;
         end
         default: ;
      endcase
   end

   vgbb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .dvr   (div_dvr),
      .steps (div_steps),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // scan stage 0: test the bit, pick the table entry, step the index
   assign hit0    = (state_ff == S_SCAN) && word_ff[WORD_BITS-1]
                    && (32'(z_ff) < 32'(cfg.grid_depth)) && (m_ff == 8'd0);
   assign q_clip  = (32'(q_ff) > TAB_LAST) ? TAB_LAST : 32'(q_ff);
   assign rd_addr = TAB_AW'(q_clip);
   assign r_sum   = {1'b0, r_ff} + {1'b0, dr_ff};
   assign r_wrap  = (r_sum >= {1'b0, dvr_gd});
   assign r_next  = r_wrap ? DVR_W'(r_sum - {1'b0, dvr_gd}) : r_sum[DVR_W-1:0];
   assign q_next  = q_ff + DIV_W'(dq_ff) + DIV_W'(r_wrap);
   assign m_inc   = {1'b0, m_ff} + 9'd1;
   assign m_next  = (m_inc == {1'b0, step_eff}) ? 8'd0 : m_inc[7:0];

   // depth table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_addr] <= req_data.table_value;
      end
      rd_ff <= table_mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (voxel_go) state_in = S_MULX;
         S_MULX:      state_in = S_MULY;
         S_MULY:      state_in = S_MULN;
         S_MULN:      state_in = S_DIVN_GO;
         S_DIVN_GO:   state_in = S_DIVN_WAIT;
         S_DIVN_WAIT: if (div_done) state_in = S_DIVS_GO;
         S_DIVS_GO:   state_in = S_DIVS_WAIT;
         S_DIVS_WAIT: if (div_done) state_in = S_DIVM_GO;
         S_DIVM_GO:   state_in = S_DIVM_WAIT;
         S_DIVM_WAIT: if (div_done) state_in = S_SCAN;
         S_SCAN:      if (bit_ff == BIT_W'(WORD_BITS - 1)) state_in = S_DRAIN1;
         S_DRAIN1:    state_in = S_DRAIN2;
         S_DRAIN2:    state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= hit0;
         v2_ff    <= v1_ff;
      end
      prod_ff <= mul_p;
      case (state_ff)
         S_IDLE: begin
            if (voxel_go) begin
               cx_ff   <= req_data.col_x;
               cy_ff   <= req_data.col_y;
               z_ff    <= Z_W'(32'(req_data.word_index) * WORD_BITS);
               word_ff <= req_data.voxel_word;
            end
         end
         S_MULY: px_ff <= xy_ctr;
         S_MULN: py_ff <= xy_ctr;
         S_DIVN_WAIT: begin
            if (div_done) begin
               q_ff <= div_quo;
               r_ff <= div_rem;
            end
         end
         S_DIVS_WAIT: begin
            if (div_done) begin
               dq_ff <= div_quo[SPAN_W:0];
               dr_ff <= div_rem;
            end
         end
         S_DIVM_WAIT: begin
            if (div_done) begin
               m_ff   <= div_rem[7:0];
               bit_ff <= '0;
            end
         end
         S_SCAN: begin
            word_ff <= word_ff << 1;
            z_ff    <= z_ff + Z_W'(1);
            bit_ff  <= bit_ff + BIT_W'(1);
            q_ff    <= q_next;
            r_ff    <= r_next;
            m_ff    <= m_next;
         end
         default: ;
      endcase
   end

   // scan stage 2: product of stage 1 becomes the z center
   assign upd.hit = v2_ff;
   assign upd.x   = px_ff;
   assign upd.y   = py_ff;
   assign upd.z   = pz;

   vgbb_box u_box (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .emit      (emit),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
